@@ rtl/core/hrt_pkg.sv @@
// Shared types, constants and helpers of the heart rate tracker.
package hrt_pkg;

  localparam int unsigned RATE_DEPTH_DEF = 8;
  localparam int unsigned ADDR_W         = 5;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FINGER_THR  = 3'd0;
  localparam logic [2:0] REG_MIN_INTV    = 3'd1;
  localparam logic [2:0] REG_MAX_INTV    = 3'd2;
  localparam logic [2:0] REG_MIN_RATE    = 3'd3;
  localparam logic [2:0] REG_MAX_RATE    = 3'd4;
  localparam logic [2:0] REG_STABLE      = 3'd5;
  localparam logic [2:0] REG_DISP_CHANGE = 3'd6;
  localparam logic [2:0] REG_DISP_TMO    = 3'd7;

  localparam logic [17:0] FINGER_THR_RST  = 18'd20000;
  localparam logic [15:0] MIN_INTV_RST    = 16'd300;
  localparam logic [15:0] MAX_INTV_RST    = 16'd2000;
  localparam logic [7:0]  MIN_RATE_RST    = 8'd45;
  localparam logic [7:0]  MAX_RATE_RST    = 8'd150;
  localparam logic [3:0]  STABLE_RST      = 4'd5;
  localparam logic [15:0] DISP_CHANGE_RST = 16'd512;
  localparam logic [15:0] DISP_TMO_RST    = 16'd5000;

  // 60000 * 256: beats per minute in Q8.8 for a one millisecond interval
  localparam logic [31:0] RATE_NUMER  = 32'd15360000;
  localparam logic [15:0] VAR_SMALL   = 16'd1280;
  localparam logic [15:0] VAR_LARGE   = 16'd3840;

  typedef struct packed {
    logic [17:0] finger_threshold;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
    logic [7:0]  min_rate;
    logic [7:0]  max_rate;
    logic [3:0]  stable_beats;
    logic [15:0] display_change;
    logic [15:0] display_timeout_ms;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_IR, OP_IR_SAVE, OP_FINGER, OP_RAW_SAT,
    OP_DIV_RATE, OP_RAW_SAVE, OP_RING_RD, OP_RING_WR, OP_DIV_AVG,
    OP_AVG_SAVE, OP_SMOOTH_SET, OP_DIV_SMOOTH, OP_SMOOTH_SAVE, OP_COUNT,
    OP_REPORT, OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic finger;
    logic beat;
    logic intv_ok;
    logic intv_zero;
    logic rate_ok;
    logic sm_zero;
    logic var_big;
    logic count_ok;
  } stat_t;

  function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/core/heart_rate_bpm_tracker.sv @@
// Top level of the heart rate tracker: configuration registers, sequencer, datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | ir_sample, beat_seen, time_ms
//  result   | out_valid / out_ready| bpm_write, bpm_value, display_event, finger_present
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One sample is handled at a time, from the accepting edge to the loaded result;
// a full beat path waits on the serial rate divider, while divisions by ten and by
// the ring depth are done by reciprocal multiplication.
// The result register lets the next transfer in while the last result waits.
// Synchronous active-high reset clears the tracker state kept between samples; the rate ring is
// cleared through per-slot valid bits, so no clearing pass is needed.
module heart_rate_bpm_tracker import hrt_pkg::*; #(
  parameter int unsigned RATE_DEPTH = RATE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [17:0]       ir_sample,
  input  logic              beat_seen,
  input  logic [31:0]       time_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              bpm_write,
  output logic [15:0]       bpm_value,
  output logic              display_event,
  output logic              finger_present,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] reg_idx;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  // Register file: write on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.finger_threshold   <= FINGER_THR_RST;
      cfg.min_interval_ms    <= MIN_INTV_RST;
      cfg.max_interval_ms    <= MAX_INTV_RST;
      cfg.min_rate           <= MIN_RATE_RST;
      cfg.max_rate           <= MAX_RATE_RST;
      cfg.stable_beats       <= STABLE_RST;
      cfg.display_change     <= DISP_CHANGE_RST;
      cfg.display_timeout_ms <= DISP_TMO_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_FINGER_THR:  cfg.finger_threshold   <= pwdata[17:0];
        REG_MIN_INTV:    cfg.min_interval_ms    <= pwdata[15:0];
        REG_MAX_INTV:    cfg.max_interval_ms    <= pwdata[15:0];
        REG_MIN_RATE:    cfg.min_rate           <= pwdata[7:0];
        REG_MAX_RATE:    cfg.max_rate           <= pwdata[7:0];
        REG_STABLE:      cfg.stable_beats       <= pwdata[3:0];
        REG_DISP_CHANGE: cfg.display_change     <= pwdata[15:0];
        REG_DISP_TMO:    cfg.display_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_FINGER_THR:  prdata = {14'd0, cfg.finger_threshold};
      REG_MIN_INTV:    prdata = {16'd0, cfg.min_interval_ms};
      REG_MAX_INTV:    prdata = {16'd0, cfg.max_interval_ms};
      REG_MIN_RATE:    prdata = {24'd0, cfg.min_rate};
      REG_MAX_RATE:    prdata = {24'd0, cfg.max_rate};
      REG_STABLE:      prdata = {28'd0, cfg.stable_beats};
      REG_DISP_CHANGE: prdata = {16'd0, cfg.display_change};
      REG_DISP_TMO:    prdata = {16'd0, cfg.display_timeout_ms};
      default:         prdata = '0;
    endcase
  end

  // Sequencer: owns the handshakes and steps the datapath
  hrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: tracker state, divider, rate ring and result register
  hrt_dp #(.RATE_DEPTH(RATE_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .ir_sample      (ir_sample),
    .beat_seen      (beat_seen),
    .time_ms        (time_ms),
    .bpm_write      (bpm_write),
    .bpm_value      (bpm_value),
    .display_event  (display_event),
    .finger_present (finger_present)
  );

endmodule

@@ rtl/core/hrt_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module hrt_div import hrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] numer,
  input  logic [15:0] denom,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, quot[31]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      dvs  <= denom;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quot <= {quot[30:0], fits};
    end
  end

endmodule

@@ rtl/core/hrt_ctrl.sv @@
// Sequencer of the heart rate tracker: steps the datapath through one sample.
module hrt_ctrl import hrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_IRDIV, S_IRWAIT, S_FINGER, S_INTV, S_RATEWAIT, S_RATECHK,
    S_RING, S_AVGDIV, S_AVGWAIT, S_SMOOTH, S_SMWAIT, S_COUNT, S_REPORT, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.op     = OP_LOAD;
        state_next = S_IRDIV;
      end
      S_IRDIV: begin
        cmd.op     = OP_DIV_IR;
        state_next = S_IRWAIT;
      end
      S_IRWAIT: if (stat.div_done) begin
        cmd.op     = OP_IR_SAVE;
        state_next = S_FINGER;
      end
      S_FINGER: begin
        cmd.op     = OP_FINGER;
        state_next = (stat.finger && stat.beat) ? S_INTV : S_DONE;
      end
      S_INTV: begin
        if (!stat.intv_ok) begin
          state_next = S_DONE;
        end else if (stat.intv_zero) begin
          cmd.op     = OP_RAW_SAT;
          state_next = S_RATECHK;
        end else begin
          cmd.op     = OP_DIV_RATE;
          state_next = S_RATEWAIT;
        end
      end
      S_RATEWAIT: if (stat.div_done) begin
        cmd.op     = OP_RAW_SAVE;
        state_next = S_RATECHK;
      end
      S_RATECHK: begin
        if (stat.rate_ok) begin
          cmd.op     = OP_RING_RD;
          state_next = S_RING;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RING: begin
        cmd.op     = OP_RING_WR;
        state_next = S_AVGDIV;
      end
      S_AVGDIV: begin
        cmd.op     = OP_DIV_AVG;
        state_next = S_AVGWAIT;
      end
      S_AVGWAIT: if (stat.div_done) begin
        cmd.op     = OP_AVG_SAVE;
        state_next = S_SMOOTH;
      end
      S_SMOOTH: begin
        if (stat.sm_zero) begin
          cmd.op     = OP_SMOOTH_SET;
          state_next = S_COUNT;
        end else if (stat.var_big) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_DIV_SMOOTH;
          state_next = S_SMWAIT;
        end
      end
      S_SMWAIT: if (stat.div_done) begin
        cmd.op     = OP_SMOOTH_SAVE;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.op     = OP_COUNT;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (stat.count_ok) cmd.op = OP_REPORT;
        state_next = S_DONE;
      end
      S_DONE: if (out_free) begin
        cmd.op     = OP_LOAD_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_LOAD_OUT) out_valid <= 1'b1;
      else if (out_ready)        out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/hrt_dp.sv @@
// Datapath of the heart rate tracker: averages, rate ring, smoothing, result.
module hrt_dp import hrt_pkg::*; #(
  parameter int unsigned RATE_DEPTH = RATE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [17:0] ir_sample,
  input  logic        beat_seen,
  input  logic [31:0] time_ms,
  output logic        bpm_write,
  output logic [15:0] bpm_value,
  output logic        display_event,
  output logic        finger_present
);

  localparam int unsigned PTR_W = $clog2(RATE_DEPTH);
  localparam int unsigned SUM_W = 16 + $clog2(RATE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RATE_DEPTH - 1);

  // Division by ten: reciprocal multiply, exact for any numerator below 2^TEN_W
  localparam int unsigned TEN_W  = 30;
  localparam int unsigned TEN_SH = TEN_W + 4;
  localparam logic [TEN_W:0] TEN_MUL = (TEN_W + 1)'(((64'd1 << TEN_SH) + 64'd9) / 64'd10);

  // Division by the ring depth: same scheme over the rounded ring sum
  localparam int unsigned AVG_W  = SUM_W + 1;
  localparam int unsigned AVG_SH = AVG_W + $clog2(RATE_DEPTH);
  localparam logic [AVG_W:0] AVG_MUL = (AVG_W + 1)'(((64'd1 << AVG_SH) +
                                       64'(RATE_DEPTH) - 64'd1) / 64'(RATE_DEPTH));
  localparam logic [AVG_W-1:0] AVG_BIAS = AVG_W'(RATE_DEPTH / 2);

  // Latched sample
  logic [17:0] ir_q;
  logic        beat_q;
  logic [31:0] now_q;

  // Tracker state
  logic [25:0] ir_average;
  logic [31:0] last_beat_time;
  logic [31:0] interval;
  logic [15:0] raw;
  logic [15:0] avg;
  logic [15:0] smoothed_rate;
  logic [3:0]  valid_count;
  logic [15:0] shown_rate;
  logic [31:0] shown_time;
  logic [SUM_W-1:0] rate_sum;
  logic [PTR_W-1:0] rate_pointer;
  logic [RATE_DEPTH-1:0] slot_valid;
  logic [15:0] rate_store [RATE_DEPTH];
  logic [15:0] old_rate;
  logic        old_valid;

  // Result being built
  logic        res_write;
  logic [15:0] res_value;
  logic        res_disp;
  logic        res_fp;

  logic        div_start;
  logic [31:0] div_numer;
  logic [15:0] div_denom;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_quot;
  logic [15:0] q_sat;
  logic [15:0] var_abs;
  logic [15:0] old_eff;
  logic        disp_hit;

  logic             ten_start;
  logic [TEN_W-1:0] ten_numer;
  logic [TEN_W-1:0] ten_arg;
  logic [2*TEN_W:0] ten_prod;
  logic             ten_go;
  logic             ten_done;
  logic [25:0]      ten_quot;

  logic             avg_start;
  logic [AVG_W-1:0] avg_numer;
  logic [AVG_W-1:0] avg_arg;
  logic [2*AVG_W:0] avg_prod;
  logic             avg_go;
  logic             avg_done;
  logic [15:0]      avg_quot;

  hrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_sat   = (div_quot > 32'hFFFF) ? 16'hFFFF : div_quot[15:0];
  assign var_abs = abs_diff16(avg, smoothed_rate);
  assign old_eff = old_valid ? old_rate : 16'd0;
  assign disp_hit = (abs_diff16(smoothed_rate, shown_rate) > cfg.display_change) ||
                    ((now_q - shown_time) > {16'd0, cfg.display_timeout_ms});

  assign ten_prod = (2*TEN_W + 1)'(ten_arg) * (2*TEN_W + 1)'(TEN_MUL);
  assign avg_prod = (2*AVG_W + 1)'(avg_arg) * (2*AVG_W + 1)'(AVG_MUL);

  always_comb begin
    div_start = (cmd.op == OP_DIV_RATE);
    div_numer = RATE_NUMER + 32'(interval[15:1]);
    div_denom = interval[15:0];
    avg_start = (cmd.op == OP_DIV_AVG);
    avg_numer = AVG_W'(rate_sum) + AVG_BIAS;
    ten_start = 1'b1;
    ten_numer = '0;
    case (cmd.op)
      OP_DIV_IR: ten_numer = TEN_W'({ir_average, 3'd0}) + TEN_W'(ir_average) +
                             TEN_W'({ir_q, 8'd0}) + TEN_W'(5);
      OP_DIV_SMOOTH: begin
        if (var_abs < VAR_SMALL)
          ten_numer = TEN_W'({avg, 1'b0}) + TEN_W'(avg) + TEN_W'({smoothed_rate, 3'd0}) -
                      TEN_W'(smoothed_rate) + TEN_W'(5);
        else
          ten_numer = TEN_W'(avg) + TEN_W'({smoothed_rate, 3'd0}) + TEN_W'(smoothed_rate) +
                      TEN_W'(5);
      end
      default: ten_start = 1'b0;
    endcase
  end

  // Constant divisions: capture the numerator, then multiply and take the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      ten_go   <= 1'b0;
      ten_done <= 1'b0;
      avg_go   <= 1'b0;
      avg_done <= 1'b0;
    end else begin
      ten_go   <= ten_start;
      ten_done <= ten_go;
      avg_go   <= avg_start;
      avg_done <= avg_go;
    end
  end

  always_ff @(posedge clk) begin
    if (ten_start) ten_arg  <= ten_numer;
    if (avg_start) avg_arg  <= avg_numer;
    if (ten_go)    ten_quot <= ten_prod[TEN_SH +: 26];
    if (avg_go)    avg_quot <= avg_prod[AVG_SH +: 16];
  end

  always_comb begin
    stat.div_done  = div_done || ten_done || avg_done;
    stat.finger    = ir_average >= {cfg.finger_threshold, 8'd0};
    stat.beat      = beat_q;
    stat.intv_ok   = (interval >= {16'd0, cfg.min_interval_ms}) &&
                     (interval <= {16'd0, cfg.max_interval_ms});
    stat.intv_zero = (interval == 32'd0);
    stat.rate_ok   = (raw >= {cfg.min_rate, 8'd0}) && (raw <= {cfg.max_rate, 8'd0});
    stat.sm_zero   = (smoothed_rate == 16'd0);
    stat.var_big   = (var_abs >= VAR_LARGE);
    stat.count_ok  = (valid_count >= cfg.stable_beats);
  end

  // Rate ring: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RING_RD) old_rate <= rate_store[rate_pointer];
    if (cmd.op == OP_RING_WR) rate_store[rate_pointer] <= raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_average     <= '0;
      last_beat_time <= '0;
      smoothed_rate  <= '0;
      valid_count    <= '0;
      shown_rate     <= '0;
      shown_time     <= '0;
      rate_sum       <= '0;
      rate_pointer   <= '0;
      slot_valid     <= '0;
    end else begin
      case (cmd.op)
        OP_IR_SAVE: ir_average <= ten_quot;
        OP_FINGER: begin
          if (!stat.finger) begin
            smoothed_rate <= '0;
            valid_count   <= '0;
          end else if (beat_q) begin
            last_beat_time <= now_q;
          end
        end
        OP_RING_WR: begin
          slot_valid[rate_pointer] <= 1'b1;
          rate_sum <= rate_sum - SUM_W'(old_eff) + SUM_W'(raw);
          rate_pointer <= (rate_pointer == PTR_LAST) ? '0 : rate_pointer + 1'b1;
        end
        OP_SMOOTH_SET:  smoothed_rate <= avg;
        OP_SMOOTH_SAVE: smoothed_rate <= ten_quot[15:0];
        OP_COUNT: if (valid_count != 4'd15) valid_count <= valid_count + 4'd1;
        OP_REPORT: if (disp_hit) begin
          shown_rate <= smoothed_rate;
          shown_time <= now_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ir_q      <= ir_sample;
        beat_q    <= beat_seen;
        now_q     <= time_ms;
        res_write <= 1'b0;
        res_value <= '0;
        res_disp  <= 1'b0;
        res_fp    <= 1'b0;
      end
      OP_FINGER: begin
        res_fp   <= stat.finger;
        interval <= now_q - last_beat_time;
        if (!stat.finger) res_write <= 1'b1;
      end
      OP_RAW_SAT:  raw <= 16'hFFFF;
      OP_RAW_SAVE: raw <= q_sat;
      OP_RING_RD:  old_valid <= slot_valid[rate_pointer];
      OP_AVG_SAVE: avg <= avg_quot;
      OP_REPORT: begin
        res_write <= 1'b1;
        res_value <= smoothed_rate;
        res_disp  <= disp_hit;
      end
      OP_LOAD_OUT: begin
        bpm_write      <= res_write;
        bpm_value      <= res_value;
        display_event  <= res_disp;
        finger_present <= res_fp;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  a_disp_needs_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD_OUT) |-> (!res_disp || res_write))
    else $error("display event without write");
  a_no_finger_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD_OUT && !res_fp) |-> (res_write && res_value == 16'd0))
    else $error("no-finger result not a zero write");
`endif

endmodule
